FILE: src/tccw_pkg.sv
package tccw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    // Fixed field and state widths
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int OFFS_W   = 12;
    localparam int POS_W    = OFFS_W - 1;  // cell index, offset is twice this
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int TABC_W   = 4;           // holds a run of up to eight blanks
    localparam int M_DATA_W = 32;

    localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_GLYPH = 8'd32;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR  = 8'd13;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

FILE: src/text_console_cell_writer_unit.sv
// Text console cell writer.
// Slave stream (s_tvalid/s_tready/s_tdata) carries one character code per
// request. Master stream (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) carries
// the results: one per line feed, return, backspace or printable character,
// and one blank-cell write per column up to the next tab stop for a tab.
// m_tlast marks the final result of each request.
// cfg_we/cfg_wdata load the attribute byte that goes with every cell write;
// write it only while the block is idle.
// Flow: a request is taken in the idle state; the block then issues its
// results through a single output register, one per cycle while the receiver
// keeps taking them, and takes no new request until the last result is issued.
// One shared 11-bit adder moves the linear cell index (row*COLUMNS + column)
// at most once per result.
// A stalled receiver holds the output register; the sequencer waits until
// that result is taken before producing the next one.
// Reset: cursor to row 0, column 0, attribute 0x07, output empty.
module text_console_cell_writer_unit
#(
    parameter int COLUMNS   = tccw_pkg::DEF_COLUMNS,   // 8..128
    parameter int ROWS      = tccw_pkg::DEF_ROWS,      // 1..32
    parameter int TAB_WIDTH = tccw_pkg::DEF_TAB_WIDTH  // 1..8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // request: [7:0] char_code
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tccw_pkg::CHAR_W-1:0]   s_tdata,
    // result: [11:0] cell_offset, [19:12] glyph_byte, [27:20] attribute_byte,
    //         [31:28] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tccw_pkg::M_DATA_W-1:0] m_tdata,
    // result: [0] write_valid
    output logic                          m_tuser,
    // last_of_run
    output logic                          m_tlast,
    // attribute register
    input  logic                          cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]   cfg_wdata
);

    localparam int POS_W  = tccw_pkg::POS_W;
    localparam int COL_W  = tccw_pkg::COL_W;
    localparam int ROW_W  = tccw_pkg::ROW_W;
    localparam int TABC_W = tccw_pkg::TABC_W;
    localparam int CHAR_W = tccw_pkg::CHAR_W;
    localparam int ATTR_W = tccw_pkg::ATTR_W;
    localparam int OFFS_W = tccw_pkg::OFFS_W;

    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [TABC_W-1:0] TAB_N    = TABC_W'(TAB_WIDTH);
    localparam logic [TABC_W-1:0] PH_LAST  = TABC_W'(TAB_WIDTH - 1);
    localparam logic [POS_W-1:0]  POS_ONE  = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_COLS = POS_W'(COLUMNS);
    localparam logic [POS_W-1:0]  POS_CM1  = POS_W'(COLUMNS - 1);

    // sequencer and cursor state
    tccw_pkg::state_t    state_reg, state_next;
    logic [CHAR_W-1:0]   code_reg, code_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [POS_W-1:0]    pos_reg, pos_next;       // row*COLUMNS + column, mod 2^11
    logic [TABC_W-1:0]   phase_reg, phase_next;   // column mod TAB_WIDTH
    logic [TABC_W-1:0]   tab_left_reg, tab_left_next;
    logic [ATTR_W-1:0]   attr_reg;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic                wv_reg, wv_next;
    logic [OFFS_W-1:0]   offs_reg, offs_next;
    logic [CHAR_W-1:0]   glyph_reg, glyph_next;
    logic [ATTR_W-1:0]   oattr_reg, oattr_next;
    logic                last_reg, last_next;

    // shared cursor adder: pos + opnd, or pos - opnd
    logic [POS_W-1:0]    add_opnd;
    logic                add_sub;
    logic [POS_W-1:0]    add_sum;

    logic                out_free;
    logic                row_can_step;

    assign add_sum = pos_reg + (add_sub ? ~add_opnd : add_opnd) + POS_W'(add_sub);

    assign out_free     = !m_tvalid_reg || m_tready;
    assign row_can_step = row_reg < ROW_LAST;

    always_comb
    begin
        state_next    = state_reg;
        code_next     = code_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        tab_left_next = tab_left_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        wv_next       = wv_reg;
        offs_next     = offs_reg;
        glyph_next    = glyph_reg;
        oattr_next    = oattr_reg;
        last_next     = last_reg;
        add_opnd      = POS_ONE;
        add_sub       = 1'b0;
        s_tready      = 1'b0;

        unique case (state_reg)
            tccw_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    code_next     = s_tdata;
                    tab_left_next = TAB_N - phase_reg;  // run length fixed here
                    state_next    = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    wv_next       = 1'b0;
                    offs_next     = '0;
                    glyph_next    = '0;
                    oattr_next    = '0;
                    last_next     = 1'b1;
                    state_next    = tccw_pkg::ST_IDLE;
                    case (code_reg)
                        tccw_pkg::CODE_LF:
                        begin
                            add_opnd = POS_COLS;
                            if (row_can_step)
                            begin
                                row_next = row_reg + ROW_W'(1);
                                pos_next = add_sum;
                            end
                        end
                        tccw_pkg::CODE_CR:
                        begin
                            add_opnd   = POS_W'(col_reg);
                            add_sub    = 1'b1;
                            col_next   = '0;
                            phase_next = '0;
                            pos_next   = add_sum;
                        end
                        tccw_pkg::CODE_BS:
                        begin
                            add_sub = 1'b1;
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - COL_W'(1);
                                pos_next   = add_sum;
                                phase_next = (phase_reg == '0) ? PH_LAST
                                                               : phase_reg - TABC_W'(1);
                            end
                        end
                        default:
                        begin
                            // cell write: tab blank or printable glyph
                            wv_next    = 1'b1;
                            offs_next  = {pos_reg, 1'b0};
                            oattr_next = attr_reg;
                            if (code_reg == tccw_pkg::CODE_TAB)
                            begin
                                glyph_next    = tccw_pkg::BLANK_GLYPH;
                                tab_left_next = tab_left_reg - TABC_W'(1);
                                if (tab_left_reg != TABC_W'(1))
                                begin
                                    last_next  = 1'b0;
                                    state_next = tccw_pkg::ST_EXEC;
                                end
                            end
                            else
                            begin
                                glyph_next = code_reg;
                            end
                            if (col_reg == COL_LAST)
                            begin
                                col_next   = '0;
                                phase_next = '0;
                                if (row_can_step)
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                                else
                                begin
                                    // bottom row: back to column zero
                                    add_opnd = POS_CM1;
                                    add_sub  = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + COL_W'(1);
                                phase_next = (phase_reg == PH_LAST) ? '0
                                                                    : phase_reg + TABC_W'(1);
                            end
                            pos_next = add_sum;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tccw_pkg::ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            pos_reg      <= '0;
            phase_reg    <= '0;
            tab_left_reg <= '0;
            attr_reg     <= tccw_pkg::ATTR_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            tab_left_reg <= tab_left_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        wv_reg    <= wv_next;
        offs_reg  <= offs_next;
        glyph_reg <= glyph_next;
        oattr_reg <= oattr_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, oattr_reg, glyph_reg, offs_reg};
    assign m_tuser  = wv_reg;
    assign m_tlast  = last_reg;

    // cursor stays on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
        else $error("cursor off screen");

    // tab phase tracks column within a stop
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_LAST)
        else $error("tab phase out of range");

    // a tab run in progress has blanks left
    a_tab_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tccw_pkg::ST_EXEC && code_reg == tccw_pkg::CODE_TAB)
        |-> (tab_left_reg != '0) && (tab_left_reg <= TAB_N))
        else $error("tab run count broken");

    // cursor-only results carry zero data and end their run
    a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0) && m_tlast)
        else $error("control result not zero");

    // no new request while a run is still being issued
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("request taken mid-run");

endmodule
